[design/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: the item structs,
// the operation kinds, the status codes and the sequencer states.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int PLE_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int LEN_W        = 5;

  typedef enum logic [2:0] {
    K_INS_HEAD = 3'd0,
    K_INS_TAIL = 3'd1,
    K_SHOW     = 3'd2,
    K_INS_AT   = 3'd3,
    K_DEL_HEAD = 3'd4,
    K_DEL_TAIL = 3'd5,
    K_DEL_AT   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SHOW,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]                kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] element;
    logic [LEN_W-1:0]          length;
    logic                      last;
  } out_item_t;

endpackage

[design/ple_mem.sv]
// ----------------------------------------------------------------------------
// ple_mem
// Element store: one write port, one read port, registered read data that
// holds while no read is issued.
// ----------------------------------------------------------------------------
module ple_mem #(
  parameter int DEPTH  = ple_pkg::PLE_CAPACITY,
  parameter int ADDR_W = 4
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [ADDR_W-1:0]                  wr_addr,
  input  logic signed [ple_pkg::VALUE_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [ADDR_W-1:0]                  rd_addr,
  output logic signed [ple_pkg::VALUE_W-1:0] rd_data
);
  import ple_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/ple_seq.sv]
// ----------------------------------------------------------------------------
// ple_seq
// Operation sequencer: decodes an item, keeps the element count and walks
// the store to shift entries up or down, or to stream them out for show.
// ----------------------------------------------------------------------------
module ple_seq #(
  parameter int CAPACITY = ple_pkg::PLE_CAPACITY,
  parameter int ADDR_W   = 4,
  parameter int CNT_W    = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ple_pkg::in_item_t                  in_data,
  output logic                               res_valid,
  input  logic                               res_ready,
  output ple_pkg::out_item_t                 res_data,
  output logic                               wr_en,
  output logic [ADDR_W-1:0]                  wr_addr,
  output logic signed [ple_pkg::VALUE_W-1:0] wr_data,
  output logic                               rd_en,
  output logic [ADDR_W-1:0]                  rd_addr,
  input  logic signed [ple_pkg::VALUE_W-1:0] rd_data
);
  import ple_pkg::*;

  localparam int CMP_W = POS_W + 1;

  seq_state_t                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [ADDR_W-1:0]         ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]         idx_r, idx_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      ins_r, ins_nxt;

  logic              full, empty, ins_pos_ok, del_pos_ok, ins_direct, del_direct;
  logic [ADDR_W-1:0] ins_idx, del_idx, pos_idx, ptr_inc, ptr_dec;
  logic [CNT_W-1:0]  cnt_inc, cnt_dec, cnt_upd;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              show_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    ins_r <= ins_nxt;
  end

  always_comb begin
    full       = (count_r == CNT_W'(CAPACITY));
    empty      = (count_r == '0);
    cnt_inc    = count_r + CNT_W'(1);
    cnt_dec    = count_r - CNT_W'(1);
    pos_ext    = CMP_W'(in_data.position);
    cnt_ext    = CMP_W'(count_r);
    ins_pos_ok = (in_data.position != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    del_pos_ok = (in_data.position != '0) && (pos_ext <= cnt_ext);
    pos_idx    = ADDR_W'(in_data.position - POS_W'(1));
    ptr_inc    = ptr_r + ADDR_W'(1);
    ptr_dec    = ptr_r - ADDR_W'(1);
    cnt_upd    = ins_r ? cnt_inc : cnt_dec;
    show_last  = (CNT_W'(ptr_r) + CNT_W'(1) == count_r);

    case (in_data.kind)
      K_INS_HEAD: ins_idx = '0;
      K_INS_TAIL: ins_idx = ADDR_W'(count_r);
      default:    ins_idx = pos_idx;
    endcase
    case (in_data.kind)
      K_DEL_HEAD: del_idx = '0;
      K_DEL_TAIL: del_idx = ADDR_W'(cnt_dec);
      default:    del_idx = pos_idx;
    endcase
    ins_direct = (CNT_W'(ins_idx) == count_r);
    del_direct = (CNT_W'(del_idx) == cnt_dec);
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    ins_nxt   = ins_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res_data  = '{status: ST_OK, element: '0, length: LEN_W'(count_r), last: 1'b1};
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = ptr_r;

    case (state_r)
      S_IDLE: begin
        in_ready = res_ready;
        if (in_valid && res_ready) begin
          case (in_data.kind)
            K_INS_HEAD, K_INS_TAIL, K_INS_AT: begin
              if (full) begin
                res_valid       = 1'b1;
                res_data.status = ST_FULL;
              end else if ((in_data.kind == K_INS_AT) && !ins_pos_ok) begin
                res_valid       = 1'b1;
                res_data.status = ST_INVALID;
              end else if (ins_direct) begin
                wr_en           = 1'b1;
                wr_addr         = ins_idx;
                wr_data         = in_data.value;
                count_nxt       = cnt_inc;
                res_valid       = 1'b1;
                res_data.length = LEN_W'(cnt_inc);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(cnt_dec);
                ptr_nxt   = ADDR_W'(count_r);
                idx_nxt   = ins_idx;
                val_nxt   = in_data.value;
                ins_nxt   = 1'b1;
                state_nxt = S_SHIFT_UP;
              end
            end
            K_DEL_HEAD, K_DEL_TAIL, K_DEL_AT: begin
              if (empty) begin
                res_valid       = 1'b1;
                res_data.status = ST_EMPTY;
              end else if ((in_data.kind == K_DEL_AT) && !del_pos_ok) begin
                res_valid       = 1'b1;
                res_data.status = ST_INVALID;
              end else if (del_direct) begin
                count_nxt       = cnt_dec;
                res_valid       = 1'b1;
                res_data.length = LEN_W'(cnt_dec);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = del_idx + ADDR_W'(1);
                ptr_nxt   = del_idx;
                ins_nxt   = 1'b0;
                state_nxt = S_SHIFT_DN;
              end
            end
            K_SHOW: begin
              if (empty) begin
                res_valid       = 1'b1;
                res_data.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SHOW;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        // entry ptr-1 arrived, move it one place up
        wr_en = 1'b1;
        if (ptr_dec == idx_r) begin
          state_nxt = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_dec - ADDR_W'(1);
          ptr_nxt = ptr_dec;
        end
      end
      S_SHIFT_DN: begin
        // entry ptr+1 arrived, move it one place down
        wr_en = 1'b1;
        if (CNT_W'(ptr_r) + CNT_W'(1) == cnt_dec) begin
          state_nxt = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc + ADDR_W'(1);
          ptr_nxt = ptr_inc;
        end
      end
      S_DONE: begin
        wr_en           = ins_r;
        wr_addr         = idx_r;
        wr_data         = val_r;
        res_valid       = 1'b1;
        res_data.length = LEN_W'(cnt_upd);
        if (res_ready) begin
          count_nxt = cnt_upd;
          state_nxt = S_IDLE;
        end
      end
      S_SHOW: begin
        res_valid        = 1'b1;
        res_data.element = rd_data;
        res_data.last    = show_last;
        if (res_ready) begin
          if (show_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc;
            ptr_nxt = ptr_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[design/positional_list_engine.sv]
// with no shift needed, a status item leaves in the cycle after its input item
// an insert or delete that moves entries shifts them one by one before its status item
// show streams one element item per cycle from the registered read, unless output stalls
// throughput: 1 item per cycle without a shift while the output is not stalled; a shift
// or a show holds off input until done, as the one read port walks one entry a cycle
// reset: synchronous active-low rst_n empties the list; store contents stay undefined
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with positional insert, delete and
// show, held in a synchronous element store walked by a sequencer.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ple_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ple_pkg::out_item_t out_data
);
  import ple_pkg::*;

  // address width of the store, count width holds the capacity itself
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // memory ports
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  // sequencer result side
  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  ple_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ple_seq #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // the output register takes a new item when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload only loads on a transfer into the register
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/ple_checker.sv]
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the result channel of the positional list engine,
// bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker #(
  parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input ple_pkg::out_item_t out_data
);
  import ple_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // non-ok status items carry no element
  a_err_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.element == '0)
    else $error("status item carries an element");

  // a non-ok status item ends its input's results
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.last)
    else $error("status item not marked last");

  // reported length never exceeds the capacity
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_data.length) <= CAPACITY)
    else $error("length above capacity");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind positional_list_engine ple_checker #(
  .CAPACITY (CAPACITY)
) u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
